// File: hw/rtl/rtt_timeout_estimator_assert.svh
// Assertion macros for the estimator RTL.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef RTT_TIMEOUT_ESTIMATOR_ASSERT_SVH
`define RTT_TIMEOUT_ESTIMATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RTE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RTE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rte_pkg.sv
package rte_pkg;

  localparam int TIME_W  = 32;
  localparam int GAIN_W  = 17;
  localparam int FRAC_W  = GAIN_W - 1;
  localparam int MULT_W  = 16;
  localparam int KFRAC_W = 8;
  localparam int IDX_W   = 3;
  localparam int ACC_W   = TIME_W + 2;
  localparam int STEP_W  = $clog2(GAIN_W);
  localparam int SCALE_W = TIME_W + KFRAC_W;

  localparam logic [GAIN_W-1:0] GAIN_ONE  = {1'b1, {FRAC_W{1'b0}}};
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(GAIN_W - 1);

  localparam logic [GAIN_W-1:0] SMOOTH_GAIN_RST   = GAIN_W'(8192);
  localparam logic [GAIN_W-1:0] VARIANCE_GAIN_RST = GAIN_W'(16384);
  localparam logic [MULT_W-1:0] VARIANCE_MULT_RST = MULT_W'(1024);
  localparam logic [TIME_W-1:0] DEFAULT_TMO_RST   = TIME_W'(1000000);

  typedef enum logic [IDX_W-1:0] {
    CFG_SMOOTH_GAIN   = IDX_W'(0),
    CFG_VARIANCE_GAIN = IDX_W'(1),
    CFG_VARIANCE_MULT = IDX_W'(2),
    CFG_DEFAULT_TMO   = IDX_W'(3)
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VAR_RUN,
    ST_SRTT_RUN,
    ST_TMO_GO,
    ST_TMO_RUN,
    ST_SUM,
    ST_OUT
  } seq_state_t;

  // Gains are already clamped to one; k_upd marks a write of the multiplier.
  typedef struct packed {
    logic [GAIN_W-1:0] smooth_gain;
    logic [GAIN_W-1:0] variance_gain;
    logic [MULT_W-1:0] variance_multiplier;
    logic [TIME_W-1:0] idle_tmo;
    logic              k_upd;
  } cfg_regs_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] x;
    logic [TIME_W-1:0] y;
    logic [GAIN_W-1:0] wx;
    logic [GAIN_W-1:0] wy;
  } mac_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [ACC_W-1:0]  hi;
    logic [FRAC_W-1:0] lo;
  } mac_rsp_t;

endpackage

// File: hw/rtl/rte_if.sv
interface rte_in_if import rte_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [TIME_W-1:0] rtt_ticks;

  modport source (output valid, output action, output rtt_ticks, input ready);
  modport sink (input valid, input action, input rtt_ticks, output ready);
endinterface

interface rte_out_if import rte_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] timeout_ticks;
  logic [TIME_W-1:0] smoothed_rtt;
  logic [TIME_W-1:0] rtt_variation;
  logic              estimate_valid;

  modport source (output valid, output timeout_ticks, output smoothed_rtt,
                  output rtt_variation, output estimate_valid, input ready);
  modport sink (input valid, input timeout_ticks, input smoothed_rtt,
                input rtt_variation, input estimate_valid, output ready);
endinterface

interface rte_cfg_if import rte_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [TIME_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/rtt_timeout_estimator.sv
// Channel   Direction  Payload                                              Role
// in_item   sink       action, rtt_ticks                                    query or RTT sample
// out_item  source     timeout_ticks, smoothed_rtt, rtt_variation,          one word per item
//                      estimate_valid
// cfg_wr    sink       index, data                                          register writes
//
// An RTT sample word with an estimate present makes three passes of the shared
// multiply-accumulate unit before the next word is accepted; the first sample makes one.
// A query passes straight to the output while the cached timeout is current or no estimate
// exists; after a write of the variance multiplier the scaled-variance product is formed again.
// Reset (rst_n low, synchronous) clears the estimate and loads the register defaults.
// The input takes a new word while the previous result still waits in the output register.
`include "rtt_timeout_estimator_assert.svh"

module rtt_timeout_estimator import rte_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rte_in_if.sink    in_item,
  rte_out_if.source out_item,
  rte_cfg_if.sink   cfg_wr
);

  // The estimator runs one word at a time through a small sequencer. Every
  // product goes through rte_mac, which consumes one bit of its weights per
  // cycle, so its datapath is a 34-bit three-input adder regardless of weight width.
  //
  // For a sample word with an estimate already present the order is:
  //   1. variation blend, using the deviation from the old smoothed RTT,
  //   2. smoothed RTT blend, from the old smoothed RTT and the latched sample,
  //   3. k * variation, scaled down by the eight fraction bits of k,
  //   4. saturating add of the smoothed RTT, stored as the cached timeout.
  // The first sample loads the estimates directly and skips to step 3.

  seq_state_t        state_r, state_nxt;
  logic              have_r, have_nxt;
  logic              fresh_r, fresh_nxt;
  logic [TIME_W-1:0] srtt_r, srtt_nxt;
  logic [TIME_W-1:0] var_r, var_nxt;
  logic [TIME_W-1:0] sample_r, sample_nxt;
  logic [SCALE_W-1:0] scaled_r, scaled_nxt;
  logic [TIME_W-1:0] tmo_r, tmo_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [TIME_W-1:0] out_tmo_r, out_srtt_r, out_var_r;
  logic              out_est_r;

  cfg_regs_t         cfg;
  mac_req_t          mac_req;
  mac_rsp_t          mac_rsp;

  logic              in_acc;
  logic              out_load;
  logic [TIME_W-1:0] dev;
  logic [SCALE_W:0]  tmo_sum;
  logic              tmo_ovf;

  rte_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .regs   (cfg)
  );

  rte_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .rsp   (mac_rsp)
  );

  assign in_acc = in_item.valid && in_item.ready;

  // Absolute deviation of the new sample from the current smoothed RTT.
  assign dev = (srtt_r >= in_item.rtt_ticks) ? (srtt_r - in_item.rtt_ticks)
                                             : (in_item.rtt_ticks - srtt_r);

  // The timeout saturates at the top of the time range.
  assign tmo_sum = {1'b0, SCALE_W'(srtt_r)} + {1'b0, scaled_r};
  assign tmo_ovf = |tmo_sum[SCALE_W:TIME_W];

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_item.action) begin
            state_nxt = have_r ? ST_VAR_RUN : ST_TMO_GO;
          end else if (have_r && !fresh_r) begin
            state_nxt = ST_TMO_GO;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_VAR_RUN:  if (mac_rsp.done) state_nxt = ST_SRTT_RUN;
      ST_SRTT_RUN: if (mac_rsp.done) state_nxt = ST_TMO_GO;
      ST_TMO_GO:   state_nxt = ST_TMO_RUN;
      ST_TMO_RUN:  if (mac_rsp.done) state_nxt = ST_SUM;
      ST_SUM:      state_nxt = ST_OUT;
      ST_OUT:      if (out_load) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs: input ready, multiply requests and the output load.
  always_comb begin
    in_item.ready = 1'b0;
    out_load      = 1'b0;
    mac_req.start = 1'b0;
    mac_req.x     = var_r;
    mac_req.y     = '0;
    mac_req.wx    = '0;
    mac_req.wy    = '0;
    case (state_r)
      ST_IDLE: begin
        in_item.ready = 1'b1;
        mac_req.start = in_acc && in_item.action && have_r;
        mac_req.x     = var_r;
        mac_req.y     = dev;
        mac_req.wx    = GAIN_ONE - cfg.variance_gain;
        mac_req.wy    = cfg.variance_gain;
      end
      ST_VAR_RUN: begin
        mac_req.start = mac_rsp.done;
        mac_req.x     = srtt_r;
        mac_req.y     = sample_r;
        mac_req.wx    = GAIN_ONE - cfg.smooth_gain;
        mac_req.wy    = cfg.smooth_gain;
      end
      ST_TMO_GO: begin
        mac_req.start = 1'b1;
        mac_req.x     = var_r;
        mac_req.wx    = GAIN_W'(cfg.variance_multiplier);
      end
      ST_OUT: begin
        out_load = !out_valid_r || out_item.ready;
      end
      default: ;
    endcase
  end

  // Estimator state and intermediate results.
  always_comb begin
    have_nxt   = have_r;
    fresh_nxt  = fresh_r;
    srtt_nxt   = srtt_r;
    var_nxt    = var_r;
    sample_nxt = sample_r;
    scaled_nxt = scaled_r;
    tmo_nxt    = tmo_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_item.action) begin
          sample_nxt = in_item.rtt_ticks;
          fresh_nxt  = 1'b0;
          if (!have_r) begin
            srtt_nxt = in_item.rtt_ticks;
            var_nxt  = in_item.rtt_ticks >> 1;
            have_nxt = 1'b1;
          end
        end
      end
      ST_VAR_RUN:  if (mac_rsp.done) var_nxt = mac_rsp.hi[TIME_W-1:0];
      ST_SRTT_RUN: if (mac_rsp.done) srtt_nxt = mac_rsp.hi[TIME_W-1:0];
      ST_TMO_RUN: begin
        // k is Q8.8, so the product keeps its top eight fraction bits.
        if (mac_rsp.done) begin
          scaled_nxt = {mac_rsp.hi[TIME_W-1:0], mac_rsp.lo[FRAC_W-1:KFRAC_W]};
        end
      end
      ST_SUM: begin
        tmo_nxt   = tmo_ovf ? '1 : tmo_sum[TIME_W-1:0];
        fresh_nxt = 1'b1;
      end
      default: ;
    endcase
    // A new multiplier invalidates the cached timeout.
    if (cfg.k_upd) begin
      fresh_nxt = 1'b0;
    end
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_item.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_r      <= 1'b0;
      fresh_r     <= 1'b0;
      srtt_r      <= '0;
      var_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      have_r      <= have_nxt;
      fresh_r     <= fresh_nxt;
      srtt_r      <= srtt_nxt;
      var_r       <= var_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    scaled_r <= scaled_nxt;
    tmo_r    <= tmo_nxt;
    if (out_load) begin
      // Before the first sample the default timeout is reported and the
      // estimates read as zero.
      out_tmo_r  <= have_r ? tmo_r : cfg.idle_tmo;
      out_srtt_r <= have_r ? srtt_r : '0;
      out_var_r  <= have_r ? var_r : '0;
      out_est_r  <= have_r;
    end
  end

  assign out_item.valid          = out_valid_r;
  assign out_item.timeout_ticks  = out_tmo_r;
  assign out_item.smoothed_rtt   = out_srtt_r;
  assign out_item.rtt_variation  = out_var_r;
  assign out_item.estimate_valid = out_est_r;

  `RTE_ASSERT_IMP(a_mac_start_idle, mac_req.start, !mac_rsp.busy, "multiply started while busy")
  `RTE_ASSERT_IMP(a_mac_busy_state, mac_rsp.busy || mac_rsp.done, state_r == ST_VAR_RUN || state_r == ST_SRTT_RUN || state_r == ST_TMO_RUN, "multiply active outside a run state")
  `RTE_ASSERT_NXT(a_sample_sets_have, in_acc && in_item.action, have_r, "sample did not mark the estimate valid")
  `RTE_ASSERT_IMP(a_fresh_needs_have, fresh_r, have_r, "cached timeout without an estimate")
  `RTE_ASSERT_IMP(a_invalid_zero, out_valid_r && !out_est_r, out_srtt_r == '0 && out_var_r == '0, "estimates not zero before first sample")

endmodule

// File: hw/rtl/rte_cfg.sv
module rte_cfg import rte_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  rte_cfg_if.sink    cfg_wr,
  output cfg_regs_t  regs
);

  logic [GAIN_W-1:0] smooth_r, smooth_nxt;
  logic [GAIN_W-1:0] vgain_r, vgain_nxt;
  logic [MULT_W-1:0] vmult_r, vmult_nxt;
  logic [TIME_W-1:0] dflt_r, dflt_nxt;
  logic              wr_en;
  logic              k_wr;

  assign cfg_wr.ready = 1'b1;
  assign wr_en = cfg_wr.valid;

  always_comb begin
    smooth_nxt = smooth_r;
    vgain_nxt  = vgain_r;
    vmult_nxt  = vmult_r;
    dflt_nxt   = dflt_r;
    k_wr       = 1'b0;
    if (wr_en) begin
      case (cfg_idx_t'(cfg_wr.index))
        CFG_SMOOTH_GAIN:   smooth_nxt = cfg_wr.data[GAIN_W-1:0];
        CFG_VARIANCE_GAIN: vgain_nxt  = cfg_wr.data[GAIN_W-1:0];
        CFG_VARIANCE_MULT: begin
          vmult_nxt = cfg_wr.data[MULT_W-1:0];
          k_wr      = 1'b1;
        end
        CFG_DEFAULT_TMO:   dflt_nxt   = cfg_wr.data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= SMOOTH_GAIN_RST;
      vgain_r  <= VARIANCE_GAIN_RST;
      vmult_r  <= VARIANCE_MULT_RST;
      dflt_r   <= DEFAULT_TMO_RST;
    end else begin
      smooth_r <= smooth_nxt;
      vgain_r  <= vgain_nxt;
      vmult_r  <= vmult_nxt;
      dflt_r   <= dflt_nxt;
    end
  end

  // A gain above one behaves as exactly one.
  always_comb begin
    regs.smooth_gain         = (smooth_r > GAIN_ONE) ? GAIN_ONE : smooth_r;
    regs.variance_gain       = (vgain_r > GAIN_ONE) ? GAIN_ONE : vgain_r;
    regs.variance_multiplier = vmult_r;
    regs.idle_tmo            = dflt_r;
    regs.k_upd               = k_wr;
  end

endmodule

// File: hw/rtl/rte_mac.sv
module rte_mac import rte_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mac_req_t req,
  output mac_rsp_t rsp
);

  // Serial-parallel multiply-accumulate: one bit of each weight per cycle,
  // LSB first. The low product bits shift out into lo_r; after the final
  // step hi_r holds floor((wx * x + wy * y) / 2^FRAC_W).

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [TIME_W-1:0] x_r, x_nxt;
  logic [TIME_W-1:0] y_r, y_nxt;
  logic [GAIN_W-1:0] wx_r, wx_nxt;
  logic [GAIN_W-1:0] wy_r, wy_nxt;
  logic [ACC_W-1:0]  hi_r, hi_nxt;
  logic [FRAC_W-1:0] lo_r, lo_nxt;
  logic [ACC_W-1:0]  pp;
  logic [ACC_W-1:0]  sum;

  assign pp  = (wx_r[0] ? ACC_W'(x_r) : '0) + (wy_r[0] ? ACC_W'(y_r) : '0);
  assign sum = hi_r + pp;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    wx_nxt   = wx_r;
    wy_nxt   = wy_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      x_nxt    = req.x;
      y_nxt    = req.y;
      wx_nxt   = req.wx;
      wy_nxt   = req.wy;
      hi_nxt   = '0;
      lo_nxt   = '0;
    end else if (busy_r) begin
      wx_nxt = wx_r >> 1;
      wy_nxt = wy_r >> 1;
      if (step_r == LAST_STEP) begin
        // The top weight bit carries 2^FRAC_W, so no shift on the last step.
        hi_nxt   = sum;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        hi_nxt   = sum >> 1;
        lo_nxt   = {sum[0], lo_r[FRAC_W-1:1]};
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    wx_r   <= wx_nxt;
    wy_r   <= wy_nxt;
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
  end

  always_comb begin
    rsp.busy = busy_r;
    rsp.done = done_r;
    rsp.hi   = hi_r;
    rsp.lo   = lo_r;
  end

endmodule

// File: tb/tb_rtt_timeout_estimator.sv
module tb_rtt_timeout_estimator;
  import rte_pkg::*;

  // The action bit of an input word.
  localparam logic ACT_QUERY  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Largest value a time field can hold; sums of time values saturate here.
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // The first register index past the last one the block implements.
  localparam int FIRST_SPARE_IDX = int'(CFG_DEFAULT_TMO) + 1;

  // This covers the slowest word, a sample, with margin.
  localparam int DRAIN_CYCLES = 100;
  // Length of the long receiver hold-off that makes the block back up.
  localparam int HOLD_CYCLES  = 400;
  // About 1750 words, plus the worst stalls on both sides, stay well within the limit,
  // which leaves ample room.
  localparam int CYCLE_LIMIT  = 1_500_000;

  typedef struct {
    logic [TIME_W-1:0] timeout_ticks;
    logic [TIME_W-1:0] smoothed_rtt;
    logic [TIME_W-1:0] rtt_variation;
    logic              estimate_valid;
  } rto_result_t;

  logic clk = 1'b0;
  logic rst_n;

  rte_in_if  in_if ();
  rte_out_if out_if ();
  rte_cfg_if cfg_if ();

  rtt_timeout_estimator DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_if.sink),
    .out_item (out_if.source),
    .cfg_wr   (cfg_if.sink)
  );

  always begin
    #10;
    clk = 1'b1;
    #10;
    clk = 1'b0;
  end

  // Shadow copy of the configuration registers, as the block should hold them.
  logic [GAIN_W-1:0] srtt_gain;
  logic [GAIN_W-1:0] var_gain;
  logic [MULT_W-1:0] var_mult;
  logic [TIME_W-1:0] idle_timeout;

  // Shadow copy of the estimator state.
  logic [TIME_W-1:0] est_srtt;
  logic [TIME_W-1:0] est_var;
  logic              est_have;

  // Results owed by the block, oldest first.
  rto_result_t pending_rto[$];

  int  fail_count = 0;
  int  cycle_count = 0;
  bit  sender_gaps = 1'b0;
  bit  receiver_stalls = 1'b0;
  bit  hold_request = 1'b0;

  // Weighted average in Q1.16: ((1 - g) * old + g * fresh), truncated once at the end.
  // A gain above one counts as exactly one.
  function automatic logic [TIME_W-1:0] blend_q16(logic [GAIN_W-1:0] gain,
                                                  logic [TIME_W-1:0] old_v,
                                                  logic [TIME_W-1:0] fresh_v);
    logic [63:0] g;
    logic [63:0] acc;
    g = (gain > GAIN_ONE) ? 64'(GAIN_ONE) : 64'(gain);
    acc = (64'(GAIN_ONE) - g) * 64'(old_v) + g * 64'(fresh_v);
    return TIME_W'(acc >> FRAC_W);
  endfunction

  // Timeout is the smoothed RTT plus k times the variation, k in Q8.8, saturated.
  function automatic logic [TIME_W-1:0] current_timeout();
    logic [63:0] sum;
    sum = 64'(est_srtt) + ((64'(var_mult) * 64'(est_var)) >> KFRAC_W);
    return (sum > 64'(TIME_MAX)) ? TIME_MAX : sum[TIME_W-1:0];
  endfunction

  // Applies one accepted word to the shadow state and returns the result it owes.
  function automatic rto_result_t apply_word(logic action, logic [TIME_W-1:0] rtt);
    rto_result_t r;
    logic [TIME_W-1:0] dev;
    if (action == ACT_SAMPLE) begin
      if (!est_have) begin
        est_srtt = rtt;
        est_var  = rtt >> 1;
        est_have = 1'b1;
      end else begin
        // The variation must see the smoothed RTT from before this sample.
        dev = (est_srtt >= rtt) ? est_srtt - rtt : rtt - est_srtt;
        est_var  = blend_q16(var_gain, est_var, dev);
        est_srtt = blend_q16(srtt_gain, est_srtt, rtt);
      end
    end
    if (est_have) begin
      r.timeout_ticks  = current_timeout();
      r.smoothed_rtt   = est_srtt;
      r.rtt_variation  = est_var;
      r.estimate_valid = 1'b1;
    end else begin
      r.timeout_ticks  = idle_timeout;
      r.smoothed_rtt   = '0;
      r.rtt_variation  = '0;
      r.estimate_valid = 1'b0;
    end
    return r;
  endfunction

  function automatic void load_reg(logic [IDX_W-1:0] idx, logic [TIME_W-1:0] data);
    case (idx)
      CFG_SMOOTH_GAIN:   srtt_gain    = data[GAIN_W-1:0];
      CFG_VARIANCE_GAIN: var_gain     = data[GAIN_W-1:0];
      CFG_VARIANCE_MULT: var_mult     = data[MULT_W-1:0];
      CFG_DEFAULT_TMO:   idle_timeout = data;
      default: ;  // Writes to unimplemented indexes are dropped by the block.
    endcase
  endfunction

  // Sender gap before a word: mostly none or a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (!sender_gaps) begin
      return 0;
    end
    r = $urandom_range(0, 19);
    if (r < 10) begin
      return 0;
    end else if (r < 18) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 60);
  endfunction

  // RTT samples are weighted toward realistic jitter around the current estimate,
  // with enough extremes and wild values to exercise saturation and big deviations.
  function automatic logic [TIME_W-1:0] pick_rtt();
    logic [TIME_W-1:0] d;
    case ($urandom_range(0, 11))
      0: return '0;
      1: return TIME_MAX;
      2: return TIME_W'($urandom_range(0, 255));
      3: return TIME_W'($urandom_range(0, 65535));
      4: return TIME_W'($urandom());
      5: return est_srtt;
      6, 7: d = TIME_W'($urandom_range(0, 1000));
      default: d = est_srtt >> $urandom_range(1, 8);
    endcase
    if ($urandom_range(0, 1) == 1) begin
      return (est_srtt > TIME_MAX - d) ? TIME_MAX : est_srtt + d;
    end
    return (est_srtt < d) ? '0 : est_srtt - d;
  endfunction

  // Offers one word and returns at the falling edge after it was taken.
  // Valid stays high so that the next word can follow without a gap.
  task automatic send_word(logic action, logic [TIME_W-1:0] rtt, int gap);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     = 1'b1;
    in_if.action    = action;
    in_if.rtt_ticks = rtt;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_rto.push_back(apply_word(action, rtt));
    @(negedge clk);
  endtask

  // Waits until every owed result is back, so that the block is idle.
  task automatic settle();
    in_if.valid = 1'b0;
    while (pending_rto.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [TIME_W-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    load_reg(idx, data);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Before any sample the block reports the default timeout and zero estimates.
  // Writes to unimplemented indexes must leave every register alone.
  task automatic check_idle_timeout();
    int spare;
    send_word(ACT_QUERY, TIME_W'($urandom()), 0);
    settle();
    write_reg(CFG_DEFAULT_TMO, '0);
    send_word(ACT_QUERY, TIME_W'($urandom()), 0);
    settle();
    write_reg(CFG_DEFAULT_TMO, TIME_MAX);
    for (spare = FIRST_SPARE_IDX; spare < (1 << IDX_W); spare++) begin
      write_reg(IDX_W'(spare), TIME_W'($urandom()));
    end
    send_word(ACT_QUERY, TIME_W'($urandom()), 0);
    settle();
    // The multiplier must not leak into the timeout while no estimate exists.
    write_reg(CFG_VARIANCE_MULT, TIME_W'(16'hFFFF));
    send_word(ACT_QUERY, '0, 0);
    settle();
  endtask

  // The first sample seeds the estimate; a full-scale one also overflows the timeout sum.
  task automatic check_first_sample();
    write_reg(CFG_VARIANCE_MULT, TIME_W'(VARIANCE_MULT_RST));
    send_word(ACT_SAMPLE, TIME_MAX, 0);
    send_word(ACT_QUERY, TIME_W'($urandom()), 0);
    settle();
  endtask

  // Gains of zero freeze the estimate, a gain of one replaces it, and gains above
  // one behave as one. Data bits above the gain field must be ignored.
  task automatic check_gain_limits();
    write_reg(CFG_SMOOTH_GAIN, '0);
    write_reg(CFG_VARIANCE_GAIN, '0);
    send_word(ACT_SAMPLE, '0, 0);
    settle();
    write_reg(CFG_SMOOTH_GAIN, TIME_W'(GAIN_ONE));
    write_reg(CFG_VARIANCE_GAIN, TIME_W'(GAIN_ONE));
    send_word(ACT_SAMPLE, '0, 0);
    send_word(ACT_SAMPLE, TIME_MAX, 0);
    settle();
    write_reg(CFG_SMOOTH_GAIN, TIME_W'({GAIN_W{1'b1}}));
    write_reg(CFG_VARIANCE_GAIN, TIME_W'(GAIN_ONE) + 1);
    send_word(ACT_SAMPLE, TIME_W'(12345), 0);
    settle();
    write_reg(CFG_SMOOTH_GAIN, 32'hFFFE_4000);
    write_reg(CFG_VARIANCE_GAIN, 32'hFFFE_2000);
    send_word(ACT_SAMPLE, TIME_W'(54321), 0);
    settle();
  endtask

  // A zero multiplier gives the bare smoothed RTT; the largest one saturates easily.
  // Queries right after a multiplier write take the slow path in the block.
  task automatic check_multiplier_limits();
    write_reg(CFG_VARIANCE_MULT, '0);
    send_word(ACT_QUERY, '0, 0);
    send_word(ACT_SAMPLE, TIME_W'(70000), 0);
    settle();
    write_reg(CFG_VARIANCE_MULT, TIME_W'(16'hFFFF));
    send_word(ACT_QUERY, TIME_MAX, 0);
    send_word(ACT_SAMPLE, TIME_W'(20000), 0);
    settle();
    write_reg(CFG_VARIANCE_MULT, TIME_W'(256));
    send_word(ACT_QUERY, '0, 0);
    settle();
  endtask

  // Full-range swings between the smallest and largest RTT at the reset gains.
  task automatic check_sample_limits();
    write_reg(CFG_SMOOTH_GAIN, TIME_W'(SMOOTH_GAIN_RST));
    write_reg(CFG_VARIANCE_GAIN, TIME_W'(VARIANCE_GAIN_RST));
    write_reg(CFG_VARIANCE_MULT, TIME_W'(VARIANCE_MULT_RST));
    send_word(ACT_SAMPLE, '0, 0);
    send_word(ACT_SAMPLE, TIME_MAX, 0);
    send_word(ACT_SAMPLE, '0, 0);
    send_word(ACT_SAMPLE, TIME_MAX, 0);
    send_word(ACT_QUERY, '0, 0);
    settle();
  endtask

  // The receiver stops for a long stretch while words keep coming back to back,
  // so the output register fills and the block has to refuse input.
  task automatic check_output_backpressure();
    int n;
    hold_request = 1'b1;
    for (n = 0; n < 12; n++) begin
      send_word(($urandom_range(0, 3) == 0) ? ACT_QUERY : ACT_SAMPLE, pick_rtt(), 0);
    end
    settle();
  endtask

  // One random phase: program all registers, then stream words with the
  // requested idling on each side. About three words in four are samples.
  task automatic run_random_phase(int count, logic [TIME_W-1:0] s_gain,
                                  logic [TIME_W-1:0] v_gain, logic [TIME_W-1:0] k,
                                  logic [TIME_W-1:0] dflt, bit gaps, bit stalls);
    int n;
    settle();
    write_reg(CFG_SMOOTH_GAIN, s_gain);
    write_reg(CFG_VARIANCE_GAIN, v_gain);
    write_reg(CFG_VARIANCE_MULT, k);
    write_reg(CFG_DEFAULT_TMO, dflt);
    sender_gaps     = gaps;
    receiver_stalls = stalls;
    for (n = 0; n < count; n++) begin
      send_word(($urandom_range(0, 3) == 0) ? ACT_QUERY : ACT_SAMPLE, pick_rtt(),
                pick_gap());
    end
    settle();
  endtask

  // Result side ready. Outside a hold-off it stalls at random while stalls are
  // enabled: mostly briefly, once in a while for much longer.
  initial begin : result_receiver
    int len;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_if.ready = 1'b1;
      end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 80) : $urandom_range(1, 3);
        out_if.ready = 1'b0;
        repeat (len) @(negedge clk);
        out_if.ready = 1'b1;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  // Every accepted result word is matched against the oldest owed result.
  always @(posedge clk) begin : check_results
    rto_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_rto.size() == 0) begin
        $error("result word arrived with no result owed");
        fail_count++;
      end else begin
        want = pending_rto.pop_front();
        if (out_if.timeout_ticks !== want.timeout_ticks) begin
          $error("timeout_ticks: expected %0d, got %0d", want.timeout_ticks,
                 out_if.timeout_ticks);
          fail_count++;
        end
        if (out_if.smoothed_rtt !== want.smoothed_rtt) begin
          $error("smoothed_rtt: expected %0d, got %0d", want.smoothed_rtt,
                 out_if.smoothed_rtt);
          fail_count++;
        end
        if (out_if.rtt_variation !== want.rtt_variation) begin
          $error("rtt_variation: expected %0d, got %0d", want.rtt_variation,
                 out_if.rtt_variation);
          fail_count++;
        end
        if (out_if.estimate_valid !== want.estimate_valid) begin
          $error("estimate_valid: expected %0d, got %0d", want.estimate_valid,
                 out_if.estimate_valid);
          fail_count++;
        end
      end
    end
  end

  // A hung handshake anywhere ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.action    = ACT_QUERY;
    in_if.rtt_ticks = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_SMOOTH_GAIN;
    cfg_if.data     = '0;

    // The shadow state starts from the reset values of the block.
    srtt_gain    = SMOOTH_GAIN_RST;
    var_gain     = VARIANCE_GAIN_RST;
    var_mult     = VARIANCE_MULT_RST;
    idle_timeout = DEFAULT_TMO_RST;
    est_srtt     = '0;
    est_var      = '0;
    est_have     = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    check_idle_timeout();
    check_first_sample();
    check_gain_limits();
    check_multiplier_limits();
    check_sample_limits();

    receiver_stalls = 1'b1;
    check_output_backpressure();

    // The phases sweep the gains and the multiplier through their extremes,
    // and switch idling on each side on and off.
    run_random_phase(215, TIME_W'(SMOOTH_GAIN_RST), TIME_W'(VARIANCE_GAIN_RST),
                     TIME_W'(VARIANCE_MULT_RST), DEFAULT_TMO_RST, 1'b1, 1'b1);
    run_random_phase(215, TIME_W'(GAIN_ONE), TIME_W'(GAIN_ONE), 32'hFFFF,
                     TIME_W'($urandom()), 1'b0, 1'b0);
    run_random_phase(215, '0, '0, '0, '0, 1'b1, 1'b0);
    run_random_phase(215, 1, 1, 1, TIME_MAX, 1'b0, 1'b1);
    run_random_phase(215, $urandom(), $urandom(), $urandom(), $urandom(), 1'b1, 1'b1);
    run_random_phase(215, 32'h1FFFF, TIME_W'(GAIN_ONE) + 1, 256, $urandom(), 1'b1, 1'b1);
    run_random_phase(215, $urandom_range(0, 65536), $urandom_range(0, 65536),
                     $urandom_range(0, 65535), $urandom(), 1'b1, 1'b1);
    run_random_phase(215, 32768, 4096, 2048, $urandom(), 1'b0, 1'b1);

    // Give a stray extra result time to show up before the verdict.
    receiver_stalls = 1'b0;
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_rto.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
